// File: hdl/fprb_pkg.sv
// ----------------------------------------------------------------------------
// fprb_pkg
// Shared types and constants of the free page range bitmap: action and
// register codes, sequencer states and the control word of the map store.
// ----------------------------------------------------------------------------
package fprb_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W    = 64;
    localparam int LEN_W     = 29;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 64;
    localparam int WORD_W    = 64;

    // Action codes of an input word
    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_MARK   = 2'd1,
        ACT_COMMIT = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

    // Result codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MK_SUM,
        ST_MK_CLAMP,
        ST_MK_CMP,
        ST_MK_ROUND,
        ST_MK_PAGES,
        ST_MK_CHK,
        ST_MK_WALK,
        ST_Q_SUB,
        ST_Q_CHK,
        ST_Q_BIT,
        ST_DONE
    } t_state;

    // Control word from the sequencer to the map store
    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_en;
    } t_map_ctl;

endpackage

// File: hdl/fprb_map.sv
// ----------------------------------------------------------------------------
// fprb_map
// Bitmap store, one 64-bit word per 64 pages. One read and one write port,
// registered read data. A clear request starts a sweep that zeroes one word
// per cycle; the store reports busy until the sweep is through.
// ----------------------------------------------------------------------------
module fprb_map #(
    parameter int MAP_WORDS = 1024,
    parameter int AW        = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fprb_pkg::t_map_ctl           i_ctl,
    input  logic [AW-1:0]                i_rd_addr,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [fprb_pkg::WORD_W-1:0]  i_wr_data,
    output logic [fprb_pkg::WORD_W-1:0]  o_rd_data,
    output logic                         o_busy
);
    import fprb_pkg::*;

    logic [WORD_W-1:0] r_mem [MAP_WORDS];
    logic [WORD_W-1:0] r_rd_data;
    logic              r_busy;
    logic [AW-1:0]     r_sweep_addr;
    logic              n_busy;
    logic [AW-1:0]     n_sweep_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    // Advance the clearing sweep; a new clear restarts it at word zero
    always_comb begin
        n_busy       = r_busy;
        n_sweep_addr = r_sweep_addr;
        if (i_ctl.clear) begin
            n_busy       = 1'b1;
            n_sweep_addr = '0;
        end else if (r_busy) begin
            if (r_sweep_addr == AW'(MAP_WORDS - 1)) begin
                n_busy = 1'b0;
            end else begin
                n_sweep_addr = r_sweep_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_sweep_addr <= '0;
        end else begin
            r_busy       <= n_busy;
            r_sweep_addr <= n_sweep_addr;
        end
    end

    // Sweep owns the write port while it runs
    always_comb begin
        wr_en   = r_busy | i_ctl.wr_en;
        wr_addr = r_busy ? r_sweep_addr : i_wr_addr;
        wr_data = r_busy ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

// File: hdl/free_page_range_bitmap.sv
// ----------------------------------------------------------------------------
// free_page_range_bitmap
// Free page bitmap over a configured address window: clear, mark a free
// range, commit, and query a page, with one result word per input word.
// ----------------------------------------------------------------------------
// Flow: one input word at a time, run by a small sequencer over a
// one-read, one-write map store of ceil(MAX_PAGES/64) words. A mark walks
// every map word that its range touches, up to ceil(MAX_PAGES/64) of them. A
// clear returns its result while the store zeroes one word per cycle, and
// the next input word is taken only once that sweep is through; the same
// sweep runs after reset and after every configuration write. PAGE_BYTES
// must be a power of two. The result register lets the next input word in
// while a result waits downstream.
// ----------------------------------------------------------------------------
module free_page_range_bitmap #(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fprb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fprb_pkg::CFG_W-1:0]      i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_action,
    input  logic [fprb_pkg::ADDR_W-1:0]     i_addr,
    input  logic [fprb_pkg::ADDR_W-1:0]     i_range_length,
    input  logic                            i_initial_round,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_status,
    output logic                            o_is_free,
    output logic                            o_skip_copy
);
    import fprb_pkg::*;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int MAP_WORDS  = (MAX_PAGES + 63) / 64;
    localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PG_W       = $clog2(MAX_PAGES + 1);
    localparam int SH_W       = LEN_W - PAGE_SHIFT;
    localparam int PX_W       = (PG_W > SH_W) ? PG_W : SH_W;
    localparam int UP_W       = ADDR_W - PAGE_SHIFT + 1;

    // Configuration and window
    logic [ADDR_W-1:0]  r_win_base;
    logic [LEN_W-1:0]   r_win_len;
    logic [ADDR_W:0]    r_win_end;
    logic               cfg_acc;

    // Sequencer
    t_state             r_state, n_state;
    logic               r_map_valid, n_map_valid;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [ADDR_W-1:0]  r_len, n_len;
    logic               r_init, n_init;
    logic [ADDR_W-1:0]  r_start, n_start;
    logic [ADDR_W-1:0]  r_end, n_end;
    logic [PX_W-1:0]    r_pg_first, n_pg_first;
    logic [PX_W-1:0]    r_pg_last, n_pg_last;
    logic [AW-1:0]      r_word, n_word;
    logic               r_q_out, n_q_out;
    logic [LEN_W-1:0]   r_q_off, n_q_off;
    logic [5:0]         r_q_bit, n_q_bit;
    logic               r_res_status, n_res_status;
    logic               r_res_free, n_res_free;
    logic               r_res_skip, n_res_skip;

    // Result register
    logic               r_o_valid, n_o_valid;
    logic               r_o_status, n_o_status;
    logic               r_o_free, n_o_free;
    logic               r_o_skip, n_o_skip;

    // Map store interface
    t_map_ctl           map_ctl;
    logic [AW-1:0]      map_rd_addr;
    logic [AW-1:0]      map_wr_addr;
    logic [WORD_W-1:0]  map_wr_data;
    logic [WORD_W-1:0]  map_rd_data;
    logic               map_busy;

    // Datapath helpers
    logic               in_acc;
    logic [ADDR_W:0]    sum;
    logic [UP_W-1:0]    rnd_up;
    logic [LEN_W-1:0]   off_s, off_e;
    logic [PX_W-1:0]    pg_s, pg_e, q_pg;
    logic [AW-1:0]      first_w, last_w;
    logic [WORD_W-1:0]  mask_lo, mask_hi;
    logic [5:0]         lo_bit;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign o_ready     = (r_state == ST_IDLE) && !map_busy;
    assign in_acc      = i_valid && o_ready;

    // Hold the window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_base <= '0;
            r_win_len  <= '0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_WINDOW_BASE:   r_win_base <= i_cfg_data;
                CFG_WINDOW_LENGTH: r_win_len  <= i_cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Window end as a 65-bit value, so it never wraps
    always_ff @(posedge i_clk) begin
        r_win_end <= {1'b0, r_win_base} + (ADDR_W + 1)'(r_win_len);
    end

    assign first_w = r_pg_first[AW+5:6];
    assign last_w  = r_pg_last[AW+5:6];

    // Sequencer: next state and datapath
    always_comb begin
        n_state      = r_state;
        n_map_valid  = r_map_valid;
        n_addr       = r_addr;
        n_len        = r_len;
        n_init       = r_init;
        n_start      = r_start;
        n_end        = r_end;
        n_pg_first   = r_pg_first;
        n_pg_last    = r_pg_last;
        n_word       = r_word;
        n_q_out      = r_q_out;
        n_q_off      = r_q_off;
        n_q_bit      = r_q_bit;
        n_res_status = r_res_status;
        n_res_free   = r_res_free;
        n_res_skip   = r_res_skip;
        map_ctl      = '0;
        map_rd_addr  = r_word;
        map_wr_addr  = r_word;
        map_wr_data  = '0;

        sum     = {1'b0, r_addr} + {1'b0, r_len};
        rnd_up  = {1'b0, r_start[ADDR_W-1:PAGE_SHIFT]} + UP_W'(1);
        off_s   = r_start[LEN_W-1:0] - r_win_base[LEN_W-1:0];
        off_e   = r_end[LEN_W-1:0] - r_win_base[LEN_W-1:0];
        pg_s    = PX_W'(off_s[LEN_W-1:PAGE_SHIFT]);
        pg_e    = PX_W'(off_e[LEN_W-1:PAGE_SHIFT]);
        q_pg    = PX_W'(r_q_off[LEN_W-1:PAGE_SHIFT]);
        lo_bit  = (r_word == first_w) ? r_pg_first[5:0] : 6'd0;
        mask_lo = {WORD_W{1'b1}} << lo_bit;
        mask_hi = (r_word == last_w) ? ({WORD_W{1'b1}} >> (6'd63 - r_pg_last[5:0]))
                                     : {WORD_W{1'b1}};

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_addr       = i_addr;
                    n_len        = i_range_length;
                    n_init       = i_initial_round;
                    n_res_status = STATUS_OK;
                    n_res_free   = 1'b0;
                    n_res_skip   = 1'b0;
                    unique case (t_action'(i_action))
                        ACT_CLEAR: begin
                            map_ctl.clear = 1'b1;
                            n_map_valid   = 1'b0;
                            n_state       = ST_DONE;
                        end
                        ACT_MARK: begin
                            n_state = ST_MK_SUM;
                        end
                        ACT_COMMIT: begin
                            if (r_win_len == '0) begin
                                n_res_status = STATUS_INVALID;
                            end else begin
                                n_map_valid = 1'b1;
                            end
                            n_state = ST_DONE;
                        end
                        ACT_QUERY: begin
                            n_state = ST_Q_SUB;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            // Drop no-map, empty and overflowing ranges
            ST_MK_SUM: begin
                if (r_win_len == '0) begin
                    n_res_status = STATUS_INVALID;
                    n_state      = ST_DONE;
                end else if (r_len == '0) begin
                    n_state = ST_DONE;
                end else if (sum[ADDR_W]) begin
                    n_res_status = STATUS_INVALID;
                    n_state      = ST_DONE;
                end else begin
                    n_end   = sum[ADDR_W-1:0];
                    n_state = ST_MK_CLAMP;
                end
            end
            // Clamp the range to the window
            ST_MK_CLAMP: begin
                n_start = (r_addr < r_win_base) ? r_win_base : r_addr;
                if ({1'b0, r_end} > r_win_end) begin
                    n_end = r_win_end[ADDR_W-1:0];
                end
                n_state = ST_MK_CMP;
            end
            ST_MK_CMP: begin
                n_state = (r_start >= r_end) ? ST_DONE : ST_MK_ROUND;
            end
            // Round inward to page edges; give up if the start wraps
            ST_MK_ROUND: begin
                if (r_start[PAGE_SHIFT-1:0] != '0) begin
                    if (rnd_up[UP_W-1]) begin
                        n_state = ST_DONE;
                    end else begin
                        n_start = {rnd_up[UP_W-2:0], {PAGE_SHIFT{1'b0}}};
                        n_state = ST_MK_PAGES;
                    end
                end else begin
                    n_state = ST_MK_PAGES;
                end
                n_end = {r_end[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            end
            // Drop a range that rounding emptied, else turn offsets into
            // page indexes and cap at the map size
            ST_MK_PAGES: begin
                if (r_start >= r_end) begin
                    n_state = ST_DONE;
                end else begin
                    n_pg_first = pg_s;
                    n_pg_last  = (pg_e > PX_W'(MAX_PAGES)) ? PX_W'(MAX_PAGES) : pg_e;
                    n_state    = ST_MK_CHK;
                end
            end
            // Start the word walk with a read of the first word
            ST_MK_CHK: begin
                if (r_pg_first >= r_pg_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_pg_last     = r_pg_last - 1'b1;
                    map_ctl.rd_en = 1'b1;
                    map_rd_addr   = first_w;
                    n_word        = first_w;
                    n_state       = ST_MK_WALK;
                end
            end
            // Write back the current word and read the next one
            ST_MK_WALK: begin
                map_ctl.wr_en = 1'b1;
                map_wr_addr   = r_word;
                map_wr_data   = map_rd_data | (mask_lo & mask_hi);
                if (r_word == last_w) begin
                    n_state = ST_DONE;
                end else begin
                    map_ctl.rd_en = 1'b1;
                    map_rd_addr   = r_word + 1'b1;
                    n_word        = r_word + 1'b1;
                end
            end
            // Offset of the queried address from the window base
            ST_Q_SUB: begin
                {n_q_out, n_q_off} = {1'b0, r_addr[LEN_W-1:0]} - {1'b0, r_win_base[LEN_W-1:0]};
                n_q_out = (r_addr < r_win_base)
                        || ((r_addr - r_win_base) >> LEN_W) != '0;
                n_state = ST_Q_CHK;
            end
            // Check window, alignment and map state, then fetch the word
            ST_Q_CHK: begin
                if (!r_q_out && r_map_valid && (r_q_off < r_win_len)
                        && (r_q_off[PAGE_SHIFT-1:0] == '0)
                        && (q_pg < PX_W'(MAX_PAGES))) begin
                    map_ctl.rd_en = 1'b1;
                    map_rd_addr   = q_pg[AW+5:6];
                    n_q_bit       = q_pg[5:0];
                    n_state       = ST_Q_BIT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_Q_BIT: begin
                n_res_free = map_rd_data[r_q_bit];
                n_res_skip = map_rd_data[r_q_bit] & r_init;
                n_state    = ST_DONE;
            end
            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // A configuration write drops the map
        if (cfg_acc) begin
            map_ctl.clear = 1'b1;
            n_map_valid   = 1'b0;
        end
    end

    // Output register
    always_comb begin
        n_o_valid  = r_o_valid && !i_ready;
        n_o_status = r_o_status;
        n_o_free   = r_o_free;
        n_o_skip   = r_o_skip;
        if (r_state == ST_DONE && (!r_o_valid || i_ready)) begin
            n_o_valid  = 1'b1;
            n_o_status = r_res_status;
            n_o_free   = r_res_free;
            n_o_skip   = r_res_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_map_valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map_valid <= n_map_valid;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_init       <= n_init;
        r_start      <= n_start;
        r_end        <= n_end;
        r_pg_first   <= n_pg_first;
        r_pg_last    <= n_pg_last;
        r_word       <= n_word;
        r_q_out      <= n_q_out;
        r_q_off      <= n_q_off;
        r_q_bit      <= n_q_bit;
        r_res_status <= n_res_status;
        r_res_free   <= n_res_free;
        r_res_skip   <= n_res_skip;
        r_o_status   <= n_o_status;
        r_o_free     <= n_o_free;
        r_o_skip     <= n_o_skip;
    end

    fprb_map #(
        .MAP_WORDS (MAP_WORDS),
        .AW        (AW)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (map_ctl),
        .i_rd_addr (map_rd_addr),
        .i_wr_addr (map_wr_addr),
        .i_wr_data (map_wr_data),
        .o_rd_data (map_rd_data),
        .o_busy    (map_busy)
    );

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_is_free   = r_o_free;
    assign o_skip_copy = r_o_skip;

endmodule

// File: bench/free_page_range_bitmap_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// free_page_range_bitmap_tb
// Self-checking bench for the free page range bitmap. A queue-fed driver
// sends clear, mark, commit and query words with random gaps, and a monitor
// with random back-pressure checks each result word against a bit-level copy
// of the page map kept in the bench. The run steps through several window
// settings: no map, a full aligned window, an unaligned small window, a
// window that ends at the top of the address space, a window larger than
// the map, a one-byte window at the last address and a random window.
// ----------------------------------------------------------------------------
module free_page_range_bitmap_tb;

    import fprb_pkg::*;

    localparam int PAGE_BYTES   = 4096;
    localparam int MAX_PAGES    = 65536;
    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int MAP_WORDS    = (MAX_PAGES + 63) / 64;
    // one full clear sweep of the map store plus some margin
    localparam int SWEEP_CYCLES = MAP_WORDS + 64;
    localparam int LIMIT_CYCLES = 4_000_000;

    typedef struct {
        t_action     act;
        logic [63:0] addr;
        logic [63:0] span;
        logic        init;
    } t_page_word;

    typedef struct packed {
        logic status;
        logic is_free;
        logic skip_copy;
    } t_page_result;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = CFG_WINDOW_BASE;
    logic [CFG_W-1:0]     i_cfg_data      = '0;
    logic                 i_valid         = 1'b0;
    logic [1:0]           i_action        = ACT_CLEAR;
    logic [ADDR_W-1:0]    i_addr          = '0;
    logic [ADDR_W-1:0]    i_range_length  = '0;
    logic                 i_initial_round = 1'b0;
    logic                 i_ready         = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_ready;
    logic                 o_valid;
    logic                 o_status;
    logic                 o_is_free;
    logic                 o_skip_copy;

    // bench copy of the block state
    logic [63:0]      free_map [MAP_WORDS];
    logic             map_committed;
    logic [63:0]      win_base;
    logic [LEN_W-1:0] win_len;

    t_page_word   queued_words [$];
    t_page_result due_results [$];
    t_page_word   live_word;
    logic         word_live;
    int           send_gap    = 0;
    logic         send_burst  = 1'b0;
    int           ready_hold  = 0;
    logic         ready_burst = 1'b0;
    logic [63:0]  hot_offset  = '0;

    int words_taken     = 0;
    int results_checked = 0;
    int free_hits       = 0;
    int mismatches      = 0;
    int cfg_writes      = 0;
    int cycles          = 0;

    free_page_range_bitmap #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_addr          (i_addr),
        .i_range_length  (i_range_length),
        .i_initial_round (i_initial_round),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_is_free       (o_is_free),
        .o_skip_copy     (o_skip_copy)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Page map prediction
    // ------------------------------------------------------------------
    function automatic void wipe_map();
        for (int w = 0; w < MAP_WORDS; w++) free_map[w] = '0;
        map_committed = 1'b0;
    endfunction

    // clamp a free range to the window, round inward to pages, set the bits
    function automatic logic mark_range(input logic [63:0] a, input logic [63:0] n);
        logic [64:0] win_end;
        logic [63:0] lo, hi, rem, first, last, p, cnt, mask;
        if (win_len == 0) return STATUS_INVALID;
        if (n == 0) return STATUS_OK;
        if (a > ~n) return STATUS_INVALID;
        lo = (a < win_base) ? win_base : a;
        hi = a + n;
        win_end = {1'b0, win_base} + 65'(win_len);
        // a window ending past the address space never clamps
        if (!win_end[64] && hi > win_end[63:0]) hi = win_end[63:0];
        if (lo >= hi) return STATUS_OK;
        rem = lo & 64'(PAGE_BYTES - 1);
        if (rem != 0) begin
            if (lo > ~(64'(PAGE_BYTES) - rem)) return STATUS_OK;
            lo = lo + (64'(PAGE_BYTES) - rem);
        end
        hi = hi & ~64'(PAGE_BYTES - 1);
        if (lo >= hi) return STATUS_OK;
        first = (lo - win_base) >> PAGE_SHIFT;
        last  = (hi - win_base) >> PAGE_SHIFT;
        if (last > 64'(MAX_PAGES)) last = 64'(MAX_PAGES);
        p = first;
        while (p < last) begin
            cnt = 64 - p[5:0];
            if (cnt > last - p) cnt = last - p;
            mask = (cnt == 64) ? '1 : (((64'd1 << cnt) - 64'd1) << p[5:0]);
            free_map[int'(p >> 6)] |= mask;
            p += cnt;
        end
        return STATUS_OK;
    endfunction

    function automatic logic page_is_free(input logic [63:0] a);
        logic [63:0] off, page;
        if (win_len == 0 || !map_committed) return 1'b0;
        if (a < win_base) return 1'b0;
        off = a - win_base;
        if (off >= 64'(win_len) || off[PAGE_SHIFT-1:0] != 0) return 1'b0;
        page = off >> PAGE_SHIFT;
        if (page >= 64'(MAX_PAGES)) return 1'b0;
        return free_map[int'(page >> 6)][page[5:0]];
    endfunction

    function automatic t_page_result apply_word(input t_page_word w);
        t_page_result r;
        r = '{STATUS_OK, 1'b0, 1'b0};
        case (w.act)
            ACT_CLEAR: wipe_map();
            ACT_MARK: r.status = mark_range(w.addr, w.span);
            ACT_COMMIT: begin
                if (win_len == 0) r.status = STATUS_INVALID;
                else map_committed = 1'b1;
            end
            default: begin
                r.is_free   = page_is_free(w.addr);
                r.skip_copy = r.is_free & w.init;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_word(input t_action act, input logic [63:0] addr,
                                       input logic [63:0] span, input logic init);
        t_page_word w;
        w.act  = act;
        w.addr = addr;
        w.span = span;
        w.init = init;
        queued_words.push_back(w);
    endfunction

    // mostly small ranges in or around the window, few large, some junk
    function automatic void queue_random_mark();
        logic [63:0] a, n;
        int span, sel;
        span = (win_len == 0) ? 16 * PAGE_BYTES : int'(win_len);
        sel  = $urandom_range(0, 19);
        a    = win_base + $urandom_range(0, span - 1);
        if ($urandom_range(0, 7) == 0) a = win_base - $urandom_range(1, 8 * PAGE_BYTES);
        if ($urandom_range(0, 3) == 0) a = a & ~64'(PAGE_BYTES - 1);
        n = $urandom_range(1, 12 * PAGE_BYTES);
        if ($urandom_range(0, 2) == 0) n = n & ~64'(PAGE_BYTES - 1);
        case (sel)
            0: begin
                a = rand64();
                n = rand64();
            end
            1: n = '0;
            2, 3: n = $urandom_range(1, 2 * span);
            default: ;
        endcase
        hot_offset = a - win_base;
        queue_word(ACT_MARK, a, n, 1'($urandom));
    endfunction

    // mostly aligned pages in the window, many near the last mark, plus edges and junk
    function automatic void queue_random_query();
        logic [63:0] a;
        int pages;
        pages = (int'(win_len) + PAGE_BYTES - 1) >> PAGE_SHIFT;
        if (pages == 0) pages = 1;
        case ($urandom_range(0, 15))
            0: a = rand64();
            1: a = win_base + (64'($urandom_range(0, pages - 1)) << PAGE_SHIFT)
                   + $urandom_range(1, PAGE_BYTES - 1);
            2: a = win_base + 64'(win_len) + (64'($urandom_range(0, 3)) << PAGE_SHIFT);
            3: a = win_base - (64'($urandom_range(1, 4)) << PAGE_SHIFT);
            4, 5, 6, 7, 8, 9:
                a = win_base + (((hot_offset >> PAGE_SHIFT) + $urandom_range(0, 3) - 1)
                    << PAGE_SHIFT);
            default: a = win_base + (64'($urandom_range(0, pages - 1)) << PAGE_SHIFT);
        endcase
        queue_word(ACT_QUERY, a, rand64(), 1'($urandom));
    endfunction

    // sessions of clear, marks, commit and queries, with some noise between
    function automatic void queue_sessions(input int count);
        int made, k;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 2) == 0) begin
                queue_word(ACT_CLEAR, rand64(), rand64(), 1'($urandom));
                made++;
            end
            k = $urandom_range(1, 5);
            repeat (k) queue_random_mark();
            made += k;
            if ($urandom_range(0, 9) != 0) begin
                queue_word(ACT_COMMIT, rand64(), rand64(), 1'($urandom));
                made++;
            end
            k = $urandom_range(3, 12);
            repeat (k) queue_random_query();
            made += k;
            k = $urandom_range(0, 3);
            repeat (k) queue_word(t_action'($urandom_range(0, 3)), rand64(), rand64(),
                                  1'($urandom));
            made += k;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WINDOW_BASE) win_base = data;
        else win_len = data[LEN_W-1:0];
        wipe_map();
        cfg_writes++;
    endtask

    task automatic set_window(input logic [63:0] base, input logic [63:0] len_data);
        write_reg(CFG_WINDOW_LENGTH, len_data);
        write_reg(CFG_WINDOW_BASE, base);
    endtask

    // drain all words and results, then let a clear sweep run out; look at
    // the falling edge so the clocked driver and monitor have settled
    task automatic settle();
        while (queued_words.size() != 0 || i_valid || due_results.size() != 0)
            @(negedge i_clk);
        repeat (SWEEP_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [63:0] b, len_data;
        win_base = '0;
        win_len  = '0;
        wipe_map();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no map present
        set_window(64'h0, 64'h0);
        queue_word(ACT_MARK, 64'h1000, 64'h2000, 1'b0);
        queue_word(ACT_MARK, 64'h1000, 64'h0, 1'b0);
        queue_word(ACT_COMMIT, 64'h0, 64'h0, 1'b0);
        queue_word(ACT_QUERY, 64'h0, 64'h0, 1'b1);
        queue_sessions(15);
        settle();

        // full aligned window
        b = 64'h0000_0000_4000_0000;
        set_window(b, 64'h1000_0000);
        queue_word(ACT_QUERY, b, '0, 1'b1);
        queue_word(ACT_MARK, '1, '0, 1'b0);
        queue_word(ACT_MARK, '1, 64'h1, 1'b0);
        queue_word(ACT_MARK, b + 64'h10, 64'h100, 1'b0);
        queue_word(ACT_MARK, b - 64'h3000, 64'h8000, 1'b0);
        queue_word(ACT_COMMIT, '0, '0, 1'b0);
        queue_word(ACT_QUERY, b, '0, 1'b1);
        queue_word(ACT_QUERY, b + 64'h800, '0, 1'b1);
        queue_word(ACT_QUERY, b - 64'h1000, '0, 1'b1);
        queue_word(ACT_MARK, 64'h0, 64'h1_0000_0000, 1'b0);
        queue_word(ACT_QUERY, b + 64'h0FFF_F000, '0, 1'b1);
        queue_word(ACT_CLEAR, '0, '0, 1'b0);
        queue_word(ACT_QUERY, b, '0, 1'b1);
        queue_word(ACT_MARK, b + 64'h0FFF_F000, 64'h1000, 1'b0);
        queue_word(ACT_COMMIT, '0, '0, 1'b0);
        queue_word(ACT_QUERY, b + 64'h0FFF_F000, '0, 1'b1);
        queue_word(ACT_QUERY, b, '0, 1'b0);
        queue_sessions(100);
        settle();

        // unaligned base, window of a little over 65 pages
        set_window(64'h0000_1234_5678_9ABC, 64'h0004_1800);
        queue_sessions(100);
        settle();

        // window running up to the very top of the address space
        b = 64'hFFFF_FFFF_F000_0000;
        set_window(b, 64'h1000_0000);
        queue_word(ACT_MARK, 64'hFFFF_FFFF_FFFF_FF01, 64'hF0, 1'b0);
        queue_word(ACT_MARK, 64'hFFFF_FFFF_FFFF_E000, 64'h1FFF, 1'b0);
        queue_word(ACT_COMMIT, '0, '0, 1'b0);
        queue_word(ACT_QUERY, 64'hFFFF_FFFF_FFFF_E000, '0, 1'b1);
        queue_sessions(100);
        settle();

        // window wider than the map, junk above the length field
        b = 64'h0000_0080_0000_0000;
        len_data = rand64();
        len_data[LEN_W-1:0] = '1;
        set_window(b, len_data);
        queue_word(ACT_MARK, b, 64'h2000_0000, 1'b0);
        queue_word(ACT_COMMIT, '0, '0, 1'b0);
        queue_word(ACT_QUERY, b + (64'(MAX_PAGES) << PAGE_SHIFT), '0, 1'b1);
        queue_word(ACT_QUERY, b + (64'(MAX_PAGES - 1) << PAGE_SHIFT), '0, 1'b1);
        queue_sessions(100);
        settle();

        // one-byte window at the last address
        set_window('1, 64'h1);
        queue_sessions(30);
        settle();

        // random window
        set_window(rand64(), 64'($urandom_range(1, 32'h1000_0000)));
        queue_sessions(60);
        settle();

        $display("Sent %0d words over %0d register writes; %0d results checked, %0d free pages.",
                 words_taken, cfg_writes, results_checked, free_hits);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: present queued words, random gap before each
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            word_live = i_valid;
            if (i_valid && o_ready) begin
                due_results.push_back(apply_word(live_word));
                words_taken++;
                word_live = 1'b0;
            end
            if (!word_live) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (queued_words.size() != 0) begin
                    live_word = queued_words.pop_front();
                    i_action        <= live_word.act;
                    i_addr          <= live_word.addr;
                    i_range_length  <= live_word.span;
                    i_initial_round <= live_word.init;
                    word_live = 1'b1;
                    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 7);
                end
            end
            i_valid <= word_live;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result word, random stall after each
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_page_result got, want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            ready_hold = 0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_status, o_is_free, o_skip_copy};
                results_checked++;
                if (got.is_free === 1'b1) free_hits++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: status=%b is_free=%b skip_copy=%b",
                                 got.status, got.is_free, got.skip_copy);
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status || got.is_free !== want.is_free ||
                        got.skip_copy !== want.skip_copy) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %b/%b/%b got %b/%b/%b (st/free/skip)",
                                     results_checked, want.status, want.is_free,
                                     want.skip_copy, got.status, got.is_free, got.skip_copy);
                    end
                end
                if ($urandom_range(0, 39) == 0) ready_burst = !ready_burst;
                ready_hold = ready_burst ? 0 : $urandom_range(0, 7);
            end else if (ready_hold > 0) begin
                ready_hold--;
            end
            i_ready <= (ready_hold == 0);
        end
    end

    // hard stop on a hang
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
